// ===== design/cheb_pkg.sv =====
`default_nettype none

package cheb_pkg;

  localparam int Q_W           = 32;
  localparam int ACC_W         = 64;
  localparam int MAX_TERMS     = 6;
  localparam int NUM_TERMS_DEF = 6;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t Q_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam acc_t Q_MIN_W = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE  = 3'd0,
    REG_OFFSET = 3'd1,
    REG_COEF_0 = 3'd2,
    REG_COEF_1 = 3'd3,
    REG_COEF_2 = 3'd4,
    REG_COEF_3 = 3'd5,
    REG_COEF_4 = 3'd6,
    REG_COEF_5 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    q_t   t;
    q_t   tm1;
    q_t   tm2;
    acc_t acc;
    logic sat;
  } cheb_item_t;

  typedef struct packed {
    logic hit;
    q_t   val;
  } sat_t;

  // Arithmetic right shift with rounding to nearest, halves toward plus infinity.
  function automatic acc_t shr_round(acc_t v, int unsigned s);
    acc_t bias;
    bias = acc_t'(1) <<< (s - 1);
    return (v + bias) >>> s;
  endfunction

  function automatic sat_t sat32(acc_t v);
    sat_t r;
    if (v > Q_MAX_W) begin
      r.hit = 1'b1;
      r.val = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < Q_MIN_W) begin
      r.hit = 1'b1;
      r.val = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r.hit = 1'b0;
      r.val = q_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cheb_sample_if.sv =====
`default_nettype none

interface cheb_sample_if import cheb_pkg::*;;
  logic valid;
  logic ready;
  q_t   sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== design/cheb_result_if.sv =====
`default_nettype none

interface cheb_result_if import cheb_pkg::*;;
  logic valid;
  logic ready;
  q_t   series_value;
  logic saturated;

  modport source (output valid, output series_value, output saturated, input ready);
  modport sink (input valid, input series_value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== design/cheb_front.sv =====
`default_nettype none

module cheb_front import cheb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       valid_in,
  input  wire q_t         sample,
  input  wire q_t         scale,
  input  wire q_t         offset,
  input  wire q_t         coef0,
  output      logic       valid_out,
  output      cheb_item_t item_out
);

  localparam q_t ONE = q_t'(64'sd1 <<< FRAC_BITS);

  logic       prod_valid;
  acc_t       prod;
  sat_t       t_sat;
  cheb_item_t item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      valid_out  <= 1'b0;
    end else if (adv) begin
      prod_valid <= valid_in;
      valid_out  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod     <= acc_t'(sample) * acc_t'(scale);
      item_out <= item_next;
    end
  end

  always_comb begin
    t_sat          = sat32(shr_round(prod, FRAC_BITS) - acc_t'(offset));
    item_next.t    = t_sat.val;
    item_next.tm1  = t_sat.val;
    item_next.tm2  = ONE;
    item_next.acc  = acc_t'(coef0);
    item_next.sat  = t_sat.hit;
  end

endmodule

`default_nettype wire

// ===== design/cheb_cell.sv =====
`default_nettype none

module cheb_cell import cheb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       valid_in,
  input  wire cheb_item_t item_in,
  input  wire q_t         coef,
  output      logic       valid_out,
  output      cheb_item_t item_out
);

  logic       vb;
  cheb_item_t itb;
  logic       vc;
  cheb_item_t itc;
  acc_t       cprod;

  if (FIRST) begin : g_first
    // The degree-one term is t itself, so the recurrence stage is skipped.
    always_ff @(posedge clk) begin
      if (rst) begin
        vb <= 1'b0;
      end else if (adv) begin
        vb <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        itb <= item_in;
      end
    end
  end else begin : g_rec
    logic       va;
    cheb_item_t ita;
    acc_t       prod;
    sat_t       tk_sat;

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
      end else if (adv) begin
        va <= valid_in;
        vb <= va;
      end
    end

    always_comb begin
      tk_sat = sat32(shr_round(prod, FRAC_BITS - 1) - acc_t'(ita.tm2));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ita      <= item_in;
        prod     <= acc_t'(item_in.t) * acc_t'(item_in.tm1);
        itb.t    <= ita.t;
        itb.tm1  <= tk_sat.val;
        itb.tm2  <= ita.tm1;
        itb.acc  <= ita.acc;
        itb.sat  <= ita.sat | tk_sat.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc        <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      vc        <= vb;
      valid_out <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itc          <= itb;
      cprod        <= acc_t'(coef) * acc_t'(itb.tm1);
      item_out.t   <= itc.t;
      item_out.tm1 <= itc.tm1;
      item_out.tm2 <= itc.tm2;
      item_out.sat <= itc.sat;
      item_out.acc <= itc.acc + shr_round(cprod, FRAC_BITS);
    end
  end

endmodule

`default_nettype wire

// ===== design/chebyshev_series_eval.sv =====
`default_nettype none

// Evaluates a Chebyshev series of NUM_TERMS terms on a shifted interval for one
// signed fixed-point sample per request, and accepts a new request every clock
// cycle unless the full pipeline is stalled at the output. The sample first
// passes a two-stage front end that forms t = scale*sample - offset, then a
// chain of cells, one per term above degree zero: the degree-one cell has a
// pass register, a coefficient multiply and an accumulate, and every higher
// cell a recurrence multiply, a rounding and clamp, a coefficient multiply
// and an accumulate. A result register follows the chain. The pipeline keeps
// moving while a result waits at the output until the last cell holds a
// result as well. The user must write registers through the write port only
// while no request is in flight; the block itself does not enforce this.
module chebyshev_series_eval import cheb_pkg::*; #(
  parameter int NUM_TERMS = NUM_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [Q_W-1:0]       cfg_data,
  cheb_sample_if.sink               samples,
  cheb_result_if.source             results
);

  localparam q_t ONE = q_t'(64'sd1 <<< FRAC_BITS);

  q_t         scale;
  q_t         offset;
  q_t         coef [MAX_TERMS];

  logic       chain_valid [NUM_TERMS];
  cheb_item_t chain_item  [NUM_TERMS];

  logic       adv;
  logic       out_load;
  logic       res_valid;
  sat_t       final_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= ONE;
      offset <= '0;
      for (int i = 0; i < MAX_TERMS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_SCALE:  scale   <= q_t'(cfg_data);
        REG_OFFSET: offset  <= q_t'(cfg_data);
        REG_COEF_0: coef[0] <= q_t'(cfg_data);
        REG_COEF_1: coef[1] <= q_t'(cfg_data);
        REG_COEF_2: coef[2] <= q_t'(cfg_data);
        REG_COEF_3: coef[3] <= q_t'(cfg_data);
        REG_COEF_4: coef[4] <= q_t'(cfg_data);
        REG_COEF_5: coef[5] <= q_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign adv           = !chain_valid[NUM_TERMS-1] || !res_valid || results.ready;
  assign samples.ready = adv;
  assign out_load      = adv && chain_valid[NUM_TERMS-1];

  cheb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .valid_in  (samples.valid),
    .sample    (samples.sample),
    .scale     (scale),
    .offset    (offset),
    .coef0     (coef[0]),
    .valid_out (chain_valid[0]),
    .item_out  (chain_item[0])
  );

  for (genvar k = 1; k < NUM_TERMS; k++) begin : g_cell
    cheb_cell #(
      .FRAC_BITS (FRAC_BITS),
      .FIRST     (k == 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .valid_in  (chain_valid[k-1]),
      .item_in   (chain_item[k-1]),
      .coef      (coef[k]),
      .valid_out (chain_valid[k]),
      .item_out  (chain_item[k])
    );
  end

  assign final_sat = sat32(chain_item[NUM_TERMS-1].acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.series_value <= final_sat.val;
      results.saturated    <= final_sat.hit | chain_item[NUM_TERMS-1].sat;
    end
  end

  assign results.valid = res_valid;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NUM_TERMS-1] && res_valid && !results.ready |-> !samples.ready)
    else $error("input accepted while the full pipeline is stalled");

  a_empty_tail_accepts: assert property (@(posedge clk) disable iff (rst)
    !chain_valid[NUM_TERMS-1] |-> samples.ready)
    else $error("input refused although the last cell is empty");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> results.valid)
    else $error("loaded result not presented");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
